// ----- sv/glyph_row_pixel_expander_macros.svh -----
// Assertion helpers used by the checker file gre_checker.sv.
`ifndef GLYPH_ROW_PIXEL_EXPANDER_MACROS_SVH
`define GLYPH_ROW_PIXEL_EXPANDER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define GRE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gre assertion failed");

// Implication checked on the following clock edge.
`define GRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gre assertion failed");

`endif

// ----- sv/gre_pkg.sv -----
package gre_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_CELL_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_LINE_PITCH    = 3'd3;
  localparam logic [2:0] CFG_PIXEL_BYTES   = 3'd4;

  // Pixel formats, coded as bytes per pixel
  localparam logic [2:0] FMT_RGB565   = 3'd2;
  localparam logic [2:0] FMT_BGR888   = 3'd3;
  localparam logic [2:0] FMT_BGRA8888 = 3'd4;

  localparam int ROW_BITS_W = 64;

  typedef struct packed {
    logic [63:0] row_bits;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  color_attr;
    logic        transparent;
  } in_item_t;

  typedef struct packed {
    logic [25:0] byte_offset;
    logic [31:0] pixel_word;
    logic [2:0]  byte_count;
    logic        is_last;
  } out_item_t;

  // Per-row values captured when a row is loaded
  typedef struct packed {
    logic [11:0] x0;
    logic [25:0] base;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [2:0]  fmt;
  } row_info_t;

  // Handshake between the row loader and the merge stage
  typedef struct packed {
    logic busy;
    logic done;
  } merge_status_t;

  // Standard 16-color VGA palette, {R, G, B}
  function automatic logic [23:0] vga_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      4'd15:   rgb = 24'hFFFFFF;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

  function automatic logic [31:0] pack_color(input logic [3:0] idx, input logic [2:0] fmt);
    logic [23:0] rgb;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] word;
    rgb = vga_rgb(idx);
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    case (fmt)
      FMT_BGRA8888: word = {8'hFF, r, g, b};
      FMT_BGR888:   word = {8'h00, r, g, b};
      default:      word = {16'h0000, r[7:3], g[7:2], b[7:3]};
    endcase
    return word;
  endfunction

endpackage

// ----- sv/gre_lanes.sv -----
module gre_lanes #(
  parameter int LANES = 64
) (
  input  gre_pkg::in_item_t  item_i,
  input  logic [6:0]         cell_width_i,
  input  logic [12:0]        screen_width_i,
  input  logic [12:0]        screen_height_i,
  input  logic [2:0]         pixel_bytes_i,
  output logic [LANES-1:0]   emit_mask_o,
  output logic [LANES-1:0]   set_mask_o
);
  import gre_pkg::*;

  logic row_ok;

  assign row_ok = (pixel_bytes_i == FMT_RGB565 || pixel_bytes_i == FMT_BGR888 ||
                   pixel_bytes_i == FMT_BGRA8888) &&
                  ({1'b0, item_i.pixel_y} < screen_height_i);

  // One lane per glyph column
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    localparam logic [6:0] COL = 7'(c);
    logic [12:0] x;
    logic        set;

    assign x   = {1'b0, item_i.pixel_x} + 13'(c);
    assign set = item_i.row_bits[ROW_BITS_W-1-c];
    assign set_mask_o[c]  = set;
    assign emit_mask_o[c] = row_ok && (COL < cell_width_i) && (x < screen_width_i) &&
                            (!item_i.transparent || set);
  end

endmodule

// ----- sv/gre_merge.sv -----
module gre_merge #(
  parameter int LANES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [LANES-1:0]       emit_mask_i,
  input  logic [LANES-1:0]       set_mask_i,
  input  gre_pkg::row_info_t     info_i,
  output gre_pkg::merge_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gre_pkg::out_item_t     out_data_o
);
  import gre_pkg::*;

  localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LANES-1:0] ONE = LANES'(1);

  logic               row_valid_q, row_valid_d;
  logic [LANES-1:0]   mask_q, mask_d;
  logic [LANES-1:0]   set_q, set_d;
  row_info_t          info_q, info_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               adv;
  logic [LANES-1:0]   low;
  logic [LANES-1:0]   rem;
  logic [IW-1:0]      col;
  logic               pix_set;
  logic [12:0]        x;
  logic [14:0]        xb;
  logic [25:0]        offset;
  logic               last;

  assign adv = !out_valid_q || out_ready_i;
  // lowest pending column, and what is left after it
  assign low  = mask_q & (~mask_q + ONE);
  assign rem  = mask_q & (mask_q - ONE);
  assign last = (rem == '0);
  assign pix_set = |(low & set_q);

  always_comb begin
    col = '0;
    for (int i = 0; i < LANES; i++) begin
      if (low[i]) col = col | IW'(i);
    end
  end

  assign x = {1'b0, info_q.x0} + 13'(col);

  always_comb begin
    case (info_q.fmt)
      FMT_RGB565: xb = 15'(x) << 1;
      FMT_BGR888: xb = (15'(x) << 1) + 15'(x);
      default:    xb = 15'(x) << 2;
    endcase
  end

  assign offset = info_q.base + 26'(xb);

  always_comb begin
    row_valid_d = row_valid_q;
    mask_d      = mask_q;
    set_d       = set_q;
    info_d      = info_q;
    if (row_valid_q && adv) begin
      mask_d      = rem;
      row_valid_d = !last;
    end
    if (load_i) begin
      row_valid_d = 1'b1;
      mask_d      = emit_mask_i;
      set_d       = set_mask_i;
      info_d      = info_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = row_valid_q;
      out_d.byte_offset = offset;
      out_d.pixel_word  = pix_set ? info_q.fg : info_q.bg;
      out_d.byte_count  = info_q.fmt;
      out_d.is_last     = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    set_q  <= set_d;
    info_q <= info_d;
    out_q  <= out_d;
  end

  assign status_o.busy = row_valid_q;
  assign status_o.done = row_valid_q && adv && last;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

endmodule

// ----- sv/glyph_row_pixel_expander.sv -----
// Channel   Direction  Handshake                  Beat
// in        input      in_valid_i / in_ready_o    one glyph row
// out       output     out_valid_o / out_ready_i  one pixel write
// cfg       input      cfg_we_i                   one register write
//
// One pixel write leaves per cycle while the output is not stalled; a row
// writes one pixel per emitted column (cell_width for an opaque row on screen,
// 8 by default). Its first pixel is registered in the row registers when the
// row is taken, then in the output register fed by the lowest-pending pick.
// Rows chain without a gap: the next row loads in the cycle its predecessor's
// last pixel moves into the output register; a row writing nothing is dropped.
// Reset clears the valid flags and loads the register defaults; a stalled
// output holds its beat and stops the row in flight.
module glyph_row_pixel_expander #(
  parameter int MAX_CELL_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gre_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gre_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [14:0]        cfg_wdata_i
);
  import gre_pkg::*;

  localparam int LANES = MAX_CELL_WIDTH;

  logic [6:0]  cell_width_q;
  logic [12:0] screen_width_q;
  logic [12:0] screen_height_q;
  logic [14:0] line_pitch_q;
  logic [2:0]  pixel_bytes_q;

  logic [LANES-1:0] emit_mask;
  logic [LANES-1:0] set_mask;
  row_info_t        info;
  merge_status_t    status;
  logic [26:0]      prod;
  logic             load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q    <= 7'd8;
      screen_width_q  <= 13'd1024;
      screen_height_q <= 13'd768;
      line_pitch_q    <= 15'd4096;
      pixel_bytes_q   <= FMT_BGRA8888;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CELL_WIDTH:    cell_width_q    <= cfg_wdata_i[6:0];
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[12:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[12:0];
        CFG_LINE_PITCH:    line_pitch_q    <= cfg_wdata_i;
        CFG_PIXEL_BYTES:   pixel_bytes_q   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  gre_lanes #(.LANES(LANES)) u_lanes (
    .item_i          (in_data_i),
    .cell_width_i    (cell_width_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .pixel_bytes_i   (pixel_bytes_q),
    .emit_mask_o     (emit_mask),
    .set_mask_o      (set_mask)
  );

  assign prod      = 27'(in_data_i.pixel_y) * 27'(line_pitch_q);
  assign info.x0   = in_data_i.pixel_x;
  assign info.base = prod[25:0];
  assign info.fg   = pack_color(in_data_i.color_attr[3:0], pixel_bytes_q);
  assign info.bg   = pack_color(in_data_i.color_attr[7:4], pixel_bytes_q);
  assign info.fmt  = pixel_bytes_q;

  // rows with nothing to write are taken and dropped here
  assign in_ready_o = !status.busy || status.done;
  assign load       = in_valid_i && in_ready_o && (|emit_mask);

  gre_merge #(.LANES(LANES)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .emit_mask_i (emit_mask),
    .set_mask_i  (set_mask),
    .info_i      (info),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/gre_checker.sv -----
`include "glyph_row_pixel_expander_macros.svh"

module gre_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input gre_pkg::out_item_t out_data_o
);
  import gre_pkg::*;

  `GRE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `GRE_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  `GRE_ASSERT(a_count_legal, clk_i, rst_ni, !out_valid_o || out_data_o.byte_count == FMT_RGB565 || out_data_o.byte_count == FMT_BGR888 || out_data_o.byte_count == FMT_BGRA8888)
  `GRE_ASSERT(a_word_fits, clk_i, rst_ni, !out_valid_o || (out_data_o.byte_count == FMT_RGB565 && out_data_o.pixel_word[31:16] == 16'h0000) || (out_data_o.byte_count == FMT_BGR888 && out_data_o.pixel_word[31:24] == 8'h00) || (out_data_o.byte_count == FMT_BGRA8888 && out_data_o.pixel_word[31:24] == 8'hFF))

endmodule

bind glyph_row_pixel_expander gre_checker u_gre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/tb_glyph_row_pixel_expander.sv -----
module tb_glyph_row_pixel_expander;
  timeunit 1ns;
  timeprecision 1ps;

  import gre_pkg::*;

  localparam int RANDOM_PHASES  = 10;
  localparam int ROWS_PER_PHASE = 20;
  localparam int SETTLE_CYCLES  = 8;

  // {R, G, B} of the 16 text-mode colors
  localparam logic [23:0] VGA_RGB [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  // One line of the directed plan: a register write or a glyph row. A row
  // either goes through the pixel predictor or carries its outcome typed in
  // (no writes at all, or a single known pixel).
  typedef struct packed {
    logic      is_cfg;
    logic [2:0]  idx;
    logic [14:0] val;
    in_item_t  row;
    logic      typed;
    logic      hit;
    out_item_t want;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_wdata = '0;

  // shadow copy of the registers
  logic [6:0]  cell_w;
  logic [12:0] scr_w;
  logic [12:0] scr_h;
  logic [14:0] pitch;
  logic [2:0]  fmt_bpp;

  out_item_t  pending_pixels[$];
  plan_step_t plan[$];
  int mismatches = 0;
  bit steady = 1'b0;
  int hold_cycles = 0;

  glyph_row_pixel_expander DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  function automatic logic [31:0] color_word(input logic [3:0] idx, input logic [2:0] fmt);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    {r, g, b} = VGA_RGB[idx];
    case (fmt)
      FMT_BGRA8888: return {8'hFF, r, g, b};
      FMT_BGR888:   return {8'h00, r, g, b};
      default:      return {16'h0000, r[7:3], g[7:2], b[7:3]};
    endcase
  endfunction

  // Pixel writes one glyph row must produce under the current registers
  function automatic void expand_row(input in_item_t it);
    out_item_t row_px[$];
    out_item_t px;
    logic [63:0] base;
    logic [31:0] fg;
    logic [31:0] bg;
    logic set;
    int width;
    int x;
    width = (cell_w > 7'd64) ? 64 : int'(cell_w);
    if (fmt_bpp != FMT_RGB565 && fmt_bpp != FMT_BGR888 && fmt_bpp != FMT_BGRA8888) return;
    if (13'(it.pixel_y) >= scr_h) return;
    fg = color_word(it.color_attr[3:0], fmt_bpp);
    bg = color_word(it.color_attr[7:4], fmt_bpp);
    base = 64'(it.pixel_y) * 64'(pitch);
    for (int col = 0; col < width; col++) begin
      x = int'(it.pixel_x) + col;
      if (x >= int'(scr_w)) break;
      set = it.row_bits[63 - col];
      if (it.transparent && !set) continue;
      px.byte_offset = 26'(base + 64'(x) * 64'(fmt_bpp));
      px.pixel_word = set ? fg : bg;
      px.byte_count = fmt_bpp;
      px.is_last = 1'b0;
      row_px.push_back(px);
    end
    if (row_px.size() > 0) row_px[row_px.size() - 1].is_last = 1'b1;
    foreach (row_px[i]) pending_pixels.push_back(row_px[i]);
  endfunction

  function automatic in_item_t make_row(input logic [63:0] bits, input int x, input int y,
                                        input logic [7:0] attr, input logic tr);
    in_item_t it;
    it.row_bits = bits;
    it.pixel_x = 12'(x);
    it.pixel_y = 12'(y);
    it.color_attr = attr;
    it.transparent = tr;
    return it;
  endfunction

  function automatic plan_step_t reg_step(input logic [2:0] idx, input logic [14:0] val);
    plan_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic plan_step_t row_step(input logic [63:0] bits, input int x, input int y,
                                          input logic [7:0] attr, input logic tr);
    plan_step_t s;
    s = '0;
    s.row = make_row(bits, x, y, attr, tr);
    return s;
  endfunction

  function automatic plan_step_t blank_step(input logic [63:0] bits, input int x, input int y,
                                            input logic [7:0] attr, input logic tr);
    plan_step_t s;
    s = row_step(bits, x, y, attr, tr);
    s.typed = 1'b1;
    return s;
  endfunction

  function automatic plan_step_t dot_step(input logic [63:0] bits, input int x, input int y,
                                          input logic [7:0] attr, input logic tr,
                                          input logic [25:0] off, input logic [31:0] word,
                                          input logic [2:0] cnt);
    plan_step_t s;
    s = blank_step(bits, x, y, attr, tr);
    s.hit = 1'b1;
    s.want = '{byte_offset: off, pixel_word: word, byte_count: cnt, is_last: 1'b1};
    return s;
  endfunction

  function automatic in_item_t rand_row();
    logic [63:0] bits;
    int width;
    int x;
    int y;
    int k;
    width = (cell_w > 7'd64) ? 64 : int'(cell_w);
    k = $urandom_range(0, 9);
    if (k == 0) bits = '0;
    else if (k == 1) bits = '1;
    else bits = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (k < 3) begin
      x = $urandom_range(0, 4095);
    end else if (k < 5) begin
      x = $urandom_range(0, 64);
    end else begin
      // straddle the right edge
      x = int'(scr_w) - width + $urandom_range(0, 16) - 8;
      if (x < 0) x = 0;
      if (x > 4095) x = 4095;
    end
    if ($urandom_range(0, 9) < 2 || scr_h == 0) y = $urandom_range(0, 4095);
    else y = $urandom_range(0, (scr_h > 13'd4096 ? 4096 : int'(scr_h)) - 1);
    return make_row(bits, x, y, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Called at a falling edge; returns at a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CELL_WIDTH:    cell_w = val[6:0];
      CFG_SCREEN_WIDTH:  scr_w = val[12:0];
      CFG_SCREEN_HEIGHT: scr_h = val[12:0];
      CFG_LINE_PITCH:    pitch = val;
      CFG_PIXEL_BYTES:   fmt_bpp = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Block quiet: every pixel seen, and a row with no writes has drained too
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_row(input in_item_t it, input logic typed, input logic hit,
                          input out_item_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (!typed) expand_row(it);
    else if (hit) pending_pixels.push_back(want);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= 1'b1;
      hold_cycles = idle_len();
    end
  end

  always @(posedge clk) begin
    out_item_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("pixel write with none pending", 64'(out_data.byte_offset), 64'd0);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_data.byte_offset !== exp_px.byte_offset)
          note_mismatch("byte_offset", 64'(out_data.byte_offset), 64'(exp_px.byte_offset));
        if (out_data.pixel_word !== exp_px.pixel_word)
          note_mismatch("pixel_word", 64'(out_data.pixel_word), 64'(exp_px.pixel_word));
        if (out_data.byte_count !== exp_px.byte_count)
          note_mismatch("byte_count", 64'(out_data.byte_count), 64'(exp_px.byte_count));
        if (out_data.is_last !== exp_px.is_last)
          note_mismatch("is_last", 64'(out_data.is_last), 64'(exp_px.is_last));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_glyph_row_pixel_expander failed");
    $finish;
  end

  initial begin
    int waited;
    cell_w = 7'd8;
    scr_w = 13'd1024;
    scr_h = 13'd768;
    pitch = 15'd4096;
    fmt_bpp = FMT_BGRA8888;

    // defaults after reset
    plan.push_back(row_step('1, 0, 0, 8'h0F, 1'b0));
    plan.push_back(blank_step('1, 0, 768, 8'h0F, 1'b0));          // row below the screen
    plan.push_back(blank_step('1, 4095, 4095, 8'hFF, 1'b1));
    plan.push_back(row_step('0, 1020, 767, 8'hF0, 1'b0));         // clipped at right edge
    plan.push_back(blank_step('0, 0, 0, 8'h5A, 1'b1));            // transparent, nothing set
    plan.push_back(row_step(64'hA5C3_0000_0000_0000, 100, 200, 8'h7E, 1'b1));
    plan.push_back(reg_step(CFG_CELL_WIDTH, 15'd1));
    plan.push_back(dot_step(64'h8000_0000_0000_0000, 0, 0, 8'h0F, 1'b0,
                            26'd0, 32'hFFFF_FFFF, FMT_BGRA8888));
    plan.push_back(dot_step('0, 1, 1, 8'h1F, 1'b0, 26'd4100, 32'hFF00_00AA, FMT_BGRA8888));
    plan.push_back(blank_step('0, 0, 0, 8'h1F, 1'b1));
    plan.push_back(reg_step(CFG_PIXEL_BYTES, 15'(FMT_RGB565)));
    plan.push_back(dot_step(64'h8000_0000_0000_0000, 0, 0, 8'h0C, 1'b0,
                            26'd0, 32'h0000_FAAA, FMT_RGB565));
    plan.push_back(reg_step(CFG_PIXEL_BYTES, 15'(FMT_BGR888)));
    plan.push_back(dot_step(64'h8000_0000_0000_0000, 2, 0, 8'h06, 1'b0,
                            26'd6, 32'h00AA_5500, FMT_BGR888));
    // byte widths without a pixel format
    plan.push_back(reg_step(CFG_PIXEL_BYTES, 15'd1));
    plan.push_back(blank_step('1, 0, 0, 8'h0F, 1'b0));
    plan.push_back(reg_step(CFG_PIXEL_BYTES, 15'd0));
    plan.push_back(blank_step('1, 0, 0, 8'h0F, 1'b0));
    plan.push_back(reg_step(CFG_PIXEL_BYTES, 15'd7));
    plan.push_back(blank_step('1, 0, 0, 8'h0F, 1'b0));
    plan.push_back(reg_step(CFG_PIXEL_BYTES, 15'(FMT_BGRA8888)));
    plan.push_back(reg_step(CFG_CELL_WIDTH, 15'd0));
    plan.push_back(blank_step('1, 0, 0, 8'h0F, 1'b0));
    plan.push_back(reg_step(CFG_CELL_WIDTH, 15'd64));
    plan.push_back(row_step(64'h0123_4567_89AB_CDEF, 0, 5, 8'h9C, 1'b0));
    plan.push_back(row_step(64'hFEDC_BA98_7654_3210, 1000, 767, 8'h3B, 1'b0));
    plan.push_back(reg_step(CFG_CELL_WIDTH, 15'd127));            // clamps to 64 columns
    plan.push_back(row_step(64'hFFFF_0000_FFFF_0000, 3, 9, 8'h2D, 1'b1));
    plan.push_back(reg_step(CFG_SCREEN_WIDTH, 15'd0));
    plan.push_back(blank_step('1, 0, 0, 8'h0F, 1'b0));
    plan.push_back(reg_step(CFG_SCREEN_WIDTH, 15'd8191));
    plan.push_back(reg_step(CFG_SCREEN_HEIGHT, 15'd8191));
    plan.push_back(reg_step(CFG_LINE_PITCH, 15'h7FFF));           // offset wraps
    plan.push_back(row_step('1, 4095, 4095, 8'hE4, 1'b0));
    plan.push_back(reg_step(CFG_SCREEN_HEIGHT, 15'd0));
    plan.push_back(blank_step('1, 0, 0, 8'h0F, 1'b0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_row(plan[i].row, plan[i].typed, plan[i].hit, plan[i].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      steady = (p % 4 == 3);
      case (p)
        0: begin
          write_reg(CFG_CELL_WIDTH, 15'd64);
          write_reg(CFG_SCREEN_WIDTH, 15'd4096);
          write_reg(CFG_SCREEN_HEIGHT, 15'd4096);
          write_reg(CFG_LINE_PITCH, 15'd16384);
          write_reg(CFG_PIXEL_BYTES, 15'(FMT_BGRA8888));
        end
        1: begin
          write_reg(CFG_CELL_WIDTH, 15'd1);
          write_reg(CFG_SCREEN_WIDTH, 15'd1);
          write_reg(CFG_SCREEN_HEIGHT, 15'd1);
          write_reg(CFG_LINE_PITCH, 15'd1);
          write_reg(CFG_PIXEL_BYTES, 15'(FMT_RGB565));
        end
        2: begin
          write_reg(CFG_CELL_WIDTH, 15'd127);
          write_reg(CFG_SCREEN_WIDTH, 15'd8191);
          write_reg(CFG_SCREEN_HEIGHT, 15'd8191);
          write_reg(CFG_LINE_PITCH, 15'h7FFF);
          write_reg(CFG_PIXEL_BYTES, 15'(FMT_BGR888));
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       write_reg(CFG_CELL_WIDTH, 15'($urandom_range(0, 127)));
            1:       write_reg(CFG_CELL_WIDTH, 15'd64);
            default: write_reg(CFG_CELL_WIDTH, 15'($urandom_range(1, 16)));
          endcase
          write_reg(CFG_SCREEN_WIDTH, 15'($urandom_range(1, 4096)));
          write_reg(CFG_SCREEN_HEIGHT, 15'($urandom_range(1, 4096)));
          if ($urandom_range(0, 7) == 0) write_reg(CFG_LINE_PITCH, 15'($urandom));
          else write_reg(CFG_LINE_PITCH, 15'($urandom_range(1, 16384)));
          case ($urandom_range(0, 9))
            0, 1, 2: write_reg(CFG_PIXEL_BYTES, 15'(FMT_RGB565));
            3, 4, 5: write_reg(CFG_PIXEL_BYTES, 15'(FMT_BGR888));
            6, 7, 8: write_reg(CFG_PIXEL_BYTES, 15'(FMT_BGRA8888));
            default: write_reg(CFG_PIXEL_BYTES, 15'($urandom_range(0, 7)));
          endcase
        end
      endcase
      repeat (ROWS_PER_PHASE) send_row(rand_row(), 1'b0, 1'b0, '0);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0)
      note_mismatch("pixel writes never delivered", 64'(pending_pixels.size()), 64'd0);
    repeat (20) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_glyph_row_pixel_expander passed");
    end else begin
      $display("tb_glyph_row_pixel_expander failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/gre_pkg.sv
sv/gre_lanes.sv
sv/gre_merge.sv
sv/glyph_row_pixel_expander.sv
sv/gre_checker.sv
test/tb_glyph_row_pixel_expander.sv
